FILE: hdl/hpsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpsm_pkg
// Shared types and constants of the hall period speed meter.
// ----------------------------------------------------------------------------
package hpsm_pkg;

    // Register field widths and reset values
    localparam int unsigned TF_W       = 32;
    localparam int unsigned PP_W       = 7;
    localparam logic [TF_W-1:0] TF_RST = 32'd72_000_000;
    localparam logic [PP_W-1:0] PP_RST = 7'd1;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic REG_TIMER_FREQ = 1'b0;
    localparam logic REG_POLE_PAIRS = 1'b1;

    // Event kinds carried in tuser
    localparam logic CMD_CAPTURE  = 1'b0;
    localparam logic CMD_OVERFLOW = 1'b1;

    // Period and datapath widths
    localparam int unsigned TICK_W = 32;
    localparam logic [TICK_W-1:0] TICK_ONES = '1;
    // 6 * pole_pairs, pole_pairs up to 127
    localparam int unsigned FAC_W  = 10;
    localparam int unsigned DEN_W  = TICK_W + FAC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_AVG,
        ST_AVG_DIV,
        ST_MUL,
        ST_SPD,
        ST_SPD_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic take_in;
        logic div_step;
        logic out_load;
    } t_ctrl;

endpackage

`default_nettype wire

FILE: hdl/hall_period_speed_meter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hall_period_speed_meter_unit
// Averaging hall-period tachometer: mean period and UQ speed per event.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per event. tuser = command (capture / overflow),
//   tdata = capture_ticks. A capture replaces the oldest of RING_DEPTH stored
//   periods; an overflow marks every stored period as all ones and keeps the
//   write slot.
//   Master stream: one beat per event with tdata = {speed_rps, average_ticks}
//   and tuser = divide_fault (divisor zero, speed saturated).
//   APB port: timer_frequency at 0x0, pole_pairs at 0x4; pready always high.
// Sequencing:
//   One event at a time. A capture passes through the ring read and
//   ring update states, an overflow goes straight to the average; then
//   come the average (a shift when RING_DEPTH is a power of two, else
//   a pass through the divider) and the speed division, in one
//   restoring shared divider. The ring RAM read is registered.
// Reset: ring reads as all ones through per-entry valid bits, write slot 0,
//   registers to their reset values; no clearing pass is needed.
// Stall: the result waits in the output register while the next event is
//   accepted and processed; a finished result is held until that register
//   empties.
// ----------------------------------------------------------------------------
module hall_period_speed_meter_unit #(
    parameter int unsigned RING_DEPTH      = 8,
    parameter int unsigned SPEED_FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] capture_ticks
    input  wire logic        i_s_tuser,   // [0] command
    // master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [31:0] average_ticks, [63:32] speed_rps_q16
    output logic             o_m_tuser,   // [0] divide_fault
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned SUM_W   = hpsm_pkg::TICK_W + $clog2(RING_DEPTH);
    localparam int unsigned NUM_W   = hpsm_pkg::TF_W + SPEED_FRAC_BITS;
    localparam int unsigned Q_W     = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int unsigned CNT_W   = $clog2(Q_W + 1);
    localparam int unsigned DEN_W   = hpsm_pkg::DEN_W;
    localparam int unsigned AVG_SHIFT = $clog2(RING_DEPTH);
    localparam bit          DEPTH_POW2 = ((RING_DEPTH & (RING_DEPTH - 1)) == 0);
    localparam logic [SUM_W-1:0] SUM_FULL =
        SUM_W'(64'(RING_DEPTH) * 64'hFFFF_FFFF);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [hpsm_pkg::TF_W-1:0] r_tf;
    logic [hpsm_pkg::PP_W-1:0] r_pp;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tf <= hpsm_pkg::TF_RST;
            r_pp <= hpsm_pkg::PP_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == hpsm_pkg::REG_TIMER_FREQ) begin
                r_tf <= pwdata;
            end else begin
                r_pp <= pwdata[hpsm_pkg::PP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == hpsm_pkg::REG_TIMER_FREQ) begin
            prdata = r_tf;
        end else begin
            prdata = {{(32 - hpsm_pkg::PP_W){1'b0}}, r_pp};
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    hpsm_pkg::t_state r_state, n_state;
    hpsm_pkg::t_ctrl  ctrl;

    logic                  r_cmd;
    logic [31:0]           r_ticks;
    logic [SLOT_W-1:0]     r_slot;
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [SUM_W-1:0]      r_sum;
    logic [31:0]           r_avg;
    logic [DEN_W-1:0]      r_den;
    logic [31:0]           r_spd;
    logic                  r_flt;

    // period ring RAM
    logic [31:0]           r_ring [RING_DEPTH];
    logic [31:0]           r_rd_data;

    // shared restoring divider
    logic [Q_W-1:0]        r_quo;
    logic [DEN_W-1:0]      r_rem;
    logic [DEN_W-1:0]      r_dsr;
    logic [CNT_W-1:0]      r_cnt;
    logic [DEN_W:0]        rem_sh;
    logic                  div_ge;
    logic                  div_last;

    // output register
    logic                  r_out_vld;
    logic [31:0]           r_out_avg;
    logic [31:0]           r_out_spd;
    logic                  r_out_flt;
    logic                  out_free;

    logic [31:0]            old_period;
    logic [hpsm_pkg::FAC_W-1:0] factor;

    assign out_free = !r_out_vld || i_m_tready;
    assign div_last = (r_cnt == CNT_W'(1));
    assign rem_sh   = {r_rem, r_quo[Q_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, r_dsr});

    // never-written entries read as all ones
    assign old_period = r_ring_vld[r_slot] ? r_rd_data : hpsm_pkg::TICK_ONES;

    // 6 * pole_pairs by shift and add
    assign factor = {r_pp, 2'b00} + {1'b0, r_pp, 1'b0};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpsm_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_s_tuser == hpsm_pkg::CMD_OVERFLOW) ?
                              hpsm_pkg::ST_AVG : hpsm_pkg::ST_READ;
                end
            end
            hpsm_pkg::ST_READ:    n_state = hpsm_pkg::ST_UPDATE;
            hpsm_pkg::ST_UPDATE:  n_state = hpsm_pkg::ST_AVG;
            hpsm_pkg::ST_AVG: begin
                n_state = DEPTH_POW2 ? hpsm_pkg::ST_MUL : hpsm_pkg::ST_AVG_DIV;
            end
            hpsm_pkg::ST_AVG_DIV: begin
                if (div_last) begin
                    n_state = hpsm_pkg::ST_MUL;
                end
            end
            hpsm_pkg::ST_MUL:     n_state = hpsm_pkg::ST_SPD;
            hpsm_pkg::ST_SPD: begin
                n_state = (r_den == '0) ? hpsm_pkg::ST_OUT : hpsm_pkg::ST_SPD_DIV;
            end
            hpsm_pkg::ST_SPD_DIV: begin
                if (div_last) begin
                    n_state = hpsm_pkg::ST_OUT;
                end
            end
            hpsm_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = hpsm_pkg::ST_IDLE;
                end
            end
            default:              n_state = hpsm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            hpsm_pkg::ST_IDLE:    ctrl.take_in  = 1'b1;
            hpsm_pkg::ST_AVG_DIV: ctrl.div_step = 1'b1;
            hpsm_pkg::ST_SPD_DIV: ctrl.div_step = 1'b1;
            hpsm_pkg::ST_OUT:     ctrl.out_load = out_free;
            default:              ctrl = '0;
        endcase
    end

    assign o_s_tready = ctrl.take_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpsm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Ring RAM: registered read of the slot, write back on update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[r_slot];
        if (r_state == hpsm_pkg::ST_UPDATE) begin
            r_ring[r_slot] <= r_ticks;
        end
    end

    // ------------------------------------------------------------------
    // Ring bookkeeping and datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_ring_vld <= '0;
            r_sum      <= SUM_FULL;
        end else begin
            if (ctrl.take_in && i_s_tvalid &&
                (i_s_tuser == hpsm_pkg::CMD_OVERFLOW)) begin
                // stall: every entry back to the all-ones mark
                r_ring_vld <= '0;
                r_sum      <= SUM_FULL;
            end else if (r_state == hpsm_pkg::ST_UPDATE) begin
                r_ring_vld[r_slot] <= 1'b1;
                r_sum  <= r_sum - SUM_W'(old_period) + SUM_W'(r_ticks);
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.take_in && i_s_tvalid) begin
            r_cmd   <= i_s_tuser;
            r_ticks <= i_s_tdata;
        end

        unique case (r_state)
            hpsm_pkg::ST_AVG: begin
                r_avg <= 32'(r_sum >> AVG_SHIFT);
                r_quo <= Q_W'(r_sum) << (Q_W - SUM_W);
                r_rem <= '0;
                r_dsr <= DEN_W'(RING_DEPTH);
                r_cnt <= CNT_W'(SUM_W);
            end
            hpsm_pkg::ST_AVG_DIV: begin
                if (div_last) begin
                    r_avg <= {r_quo[30:0], div_ge};
                end
            end
            hpsm_pkg::ST_MUL: begin
                r_den <= DEN_W'(r_avg) * DEN_W'(factor);
            end
            hpsm_pkg::ST_SPD: begin
                // zero divisor: saturate and flag
                r_spd <= '1;
                r_flt <= (r_den == '0);
                r_quo <= Q_W'(r_tf) << (Q_W - hpsm_pkg::TF_W);
                r_rem <= '0;
                r_dsr <= r_den;
                r_cnt <= CNT_W'(NUM_W);
            end
            hpsm_pkg::ST_SPD_DIV: begin
                if (div_last) begin
                    // quotient wider than 32 bits saturates
                    if (r_quo[Q_W-2:31] != '0) begin
                        r_spd <= '1;
                    end else begin
                        r_spd <= {r_quo[30:0], div_ge};
                    end
                end
            end
            default: begin
            end
        endcase

        if (ctrl.div_step) begin
            r_quo <= {r_quo[Q_W-2:0], div_ge};
            r_rem <= div_ge ? DEN_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DEN_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_avg <= r_avg;
            r_out_spd <= r_spd;
            r_out_flt <= r_flt;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_spd, r_out_avg};
    assign o_m_tuser  = r_out_flt;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ovf_clears_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.take_in && i_s_tvalid && (i_s_tuser == hpsm_pkg::CMD_OVERFLOW))
        |=> (r_ring_vld == '0) && (r_sum == SUM_FULL))
        else $error("overflow did not refill the ring");

    a_slot_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpsm_pkg::ST_UPDATE) |=>
        ((RING_DEPTH == 1) || (r_slot != $past(r_slot))))
        else $error("write slot did not advance after a capture");

    a_zero_div_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == hpsm_pkg::ST_SPD) && (r_den == '0)) |=>
        ((r_state == hpsm_pkg::ST_OUT) && r_flt && (r_spd == '1)))
        else $error("zero divisor not saturated");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == hpsm_pkg::ST_OUT))
        else $error("result loaded outside the output state");

endmodule

`default_nettype wire

FILE: verif/hall_period_speed_meter_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hall_period_speed_meter_unit_tb
// Self-checking bench for the hall period speed meter. Capture and overflow
// beats go in on the slave stream. A scoreboard keeps its own period ring
// and register copies, and works out the average period, the speed and the
// fault flag for every accepted beat. Each master beat is then checked
// against the oldest outstanding reading. Register settings are changed
// between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module hall_period_speed_meter_unit_tb;
    import hpsm_pkg::*;

    localparam int unsigned DEPTH          = 8;
    localparam int unsigned FRAC_BITS      = 16;
    localparam int unsigned EDGES_PER_REV  = 6;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned BACKLOG_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES    = 120;
    localparam int unsigned PHASE_EVENTS   = 180;
    localparam int unsigned NUM_PHASES     = 8;

    // One expected master beat, fields as the block reports them
    typedef struct packed {
        logic [31:0] average_ticks;
        logic [31:0] speed_rps_q16;
        logic        divide_fault;
    } tacho_reading_t;

    // Scoreboard: private copy of the period ring and registers, plus the
    // queue of readings still owed by the block
    class tacho_scoreboard;
        logic [31:0]    periods [DEPTH];
        int unsigned    slot;
        logic [34:0]    period_total;
        logic [31:0]    tick_rate;
        logic [6:0]     pole_pairs;
        tacho_reading_t pending [$];
        int unsigned    errors;

        function new();
            mark_stalled();
            slot       = 0;
            tick_rate  = TF_RST;
            pole_pairs = PP_RST;
            errors     = 0;
        endfunction

        // Every stored period reads as all ones after reset or a stall
        function void mark_stalled();
            foreach (periods[k]) periods[k] = TICK_ONES;
            period_total = 35'(DEPTH) * 35'(TICK_ONES);
        endfunction

        function void write_register(logic idx, logic [31:0] value);
            if (idx == REG_TIMER_FREQ) begin
                tick_rate = value;
            end else begin
                pole_pairs = value[6:0];
            end
        endfunction

        function void note_event(logic cmd, logic [31:0] ticks);
            tacho_reading_t r;
            logic [63:0]    divisor;
            logic [63:0]    scaled_rate;
            logic [63:0]    quotient;
            if (cmd == CMD_CAPTURE) begin
                // replace the oldest period, keep the total exact
                period_total = period_total - 35'(periods[slot]) + 35'(ticks);
                periods[slot] = ticks;
                slot = (slot + 1) % DEPTH;
            end else begin
                mark_stalled();
            end
            r.average_ticks = 32'(period_total / DEPTH);
            divisor     = 64'(r.average_ticks) * 64'(EDGES_PER_REV) * 64'(pole_pairs);
            scaled_rate = 64'(tick_rate) << FRAC_BITS;
            r.divide_fault = (divisor == 64'd0);
            if (divisor == 64'd0) begin
                r.speed_rps_q16 = '1;
            end else begin
                quotient = scaled_rate / divisor;
                r.speed_rps_q16 = (quotient > 64'h0000_0000_FFFF_FFFF) ? '1 : quotient[31:0];
            end
            pending.push_back(r);
        endfunction

        function void check_reading(logic [63:0] data, logic fault);
            tacho_reading_t want;
            if (pending.size() == 0) begin
                $error("result beat with no event outstanding: tdata=%h tuser=%b", data, fault);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[31:0] !== want.average_ticks) begin
                $error("average_ticks: expected %0d, got %0d", want.average_ticks, data[31:0]);
                errors++;
            end
            if (data[63:32] !== want.speed_rps_q16) begin
                $error("speed_rps_q16: expected %h, got %h", want.speed_rps_q16, data[63:32]);
                errors++;
            end
            if (fault !== want.divide_fault) begin
                $error("divide_fault: expected %b, got %b", want.divide_fault, fault);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // [31:0] capture_ticks
    logic        i_s_tuser;   // [0] command
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;   // [31:0] average_ticks, [63:32] speed_rps_q16
    logic        o_m_tuser;   // [0] divide_fault
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tacho_scoreboard tacho;
    bit              steady;            // no idling on either side while set
    int unsigned     backlog_requests;  // bump to make the sink hold off

    hall_period_speed_meter_unit #(
        .RING_DEPTH      (DEPTH),
        .SPEED_FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample both handshakes on the edge; all bench inputs change by
    // nonblocking assignment, so the pre-edge values are seen here.
    // Check the outgoing beat first: it always belongs to an older event.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            tacho.check_reading(o_m_tdata, o_m_tuser);
        end
        if (i_s_tvalid && o_s_tready) begin
            tacho.note_event(i_s_tuser, i_s_tdata);
        end
    end

    // Sink: drop tready at random, about 8 times in a hundred. On request, hold it
    // low for a long stretch so that the block backs up and stalls its input.
    initial begin : sink
        int unsigned served;
        int unsigned k;
        served = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != backlog_requests) begin
                served = backlog_requests;
                for (k = 0; k < BACKLOG_CYCLES; k++) begin
                    i_m_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_m_tready <= steady || ($urandom_range(99) >= 8);
        end
    end

    // Watchdog: give up well past the slowest legal run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one beat, with random idle cycles ahead of it, and hold it until
    // the block takes it. Leave tvalid high: the next beat may follow at once.
    task automatic send_event(input logic cmd, input logic [31:0] ticks);
        while (!steady && $urandom_range(99) < 8) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= $urandom;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= ticks;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drop tvalid and wait until every owed reading has come out
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tacho.pending.size() != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tacho.write_register(idx, value);
    endtask

    // Tick counts by magnitude band: tiny values drive the average to zero
    // or push the speed past 32 bits, the rest cover realistic and full-range
    // periods
    function automatic logic [31:0] pick_ticks(input int unsigned band);
        case (band)
            0: return 32'($urandom_range(3));
            1: return 32'($urandom_range(200_000, 1_000));
            2: return $urandom;
            default: return $urandom_range(1) ? TICK_ONES : 32'd0;
        endcase
    endfunction

    // Mostly captures; runs of a full ring of one band settle the average
    // on that band, and overflows now and then reset the ring to stall marks
    task automatic run_random_events(input int unsigned count);
        int unsigned sent;
        int unsigned roll;
        int unsigned band;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_event(CMD_OVERFLOW, $urandom);
                sent++;
            end else if (roll < 20) begin
                band = $urandom_range(3);
                repeat (DEPTH) send_event(CMD_CAPTURE, pick_ticks(band));
                sent += DEPTH;
            end else begin
                send_event(CMD_CAPTURE, pick_ticks($urandom_range(3)));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] phase_rate  [NUM_PHASES];
        logic [6:0]  phase_pairs [NUM_PHASES];
        int unsigned p;

        tacho = new();
        steady = 1'b0;
        backlog_requests = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 32'd0;
        i_s_tuser  <= CMD_CAPTURE;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 3'd0;
        pwdata     <= 32'd0;

        // Register settings per phase: extremes of both registers, a pole
        // pair count of zero (fault on every beat) and one random setting
        phase_rate[0] = 32'd1;            phase_pairs[0] = 7'd1;
        phase_rate[1] = 32'hFFFF_FFFF;    phase_pairs[1] = 7'd64;
        phase_rate[2] = 32'hFFFF_FFFF;    phase_pairs[2] = 7'd127;
        phase_rate[3] = 32'd1_000_000;    phase_pairs[3] = 7'd0;
        phase_rate[4] = 32'd72_000_000;   phase_pairs[4] = 7'd4;
        phase_rate[5] = 32'd0;            phase_pairs[5] = 7'd7;
        phase_rate[6] = $urandom;         phase_pairs[6] = 7'($urandom_range(64, 1));
        phase_rate[7] = 32'd48_000_000;   phase_pairs[7] = 7'd2;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings
        send_event(CMD_CAPTURE, 32'd0);
        // overflow keeps the write slot and ignores the tick field
        send_event(CMD_OVERFLOW, TICK_ONES);
        // fill the ring with zeros: the average reaches zero, fault raised
        repeat (DEPTH) send_event(CMD_CAPTURE, 32'd0);
        // average of one: speed too large for 32 bits, saturates with no fault
        repeat (DEPTH) send_event(CMD_CAPTURE, 32'd1);
        send_event(CMD_CAPTURE, TICK_ONES);
        send_event(CMD_CAPTURE, 32'h8000_0000);
        send_event(CMD_OVERFLOW, 32'd0);
        send_event(CMD_CAPTURE, 32'h1234_5678);

        // Random phases; change registers only once the block is empty
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_register(REG_TIMER_FREQ, phase_rate[p]);
            write_register(REG_POLE_PAIRS, 32'(phase_pairs[p]));
            steady = (p == 2);
            if (p == 1) begin
                // stall the sink while beats keep coming
                backlog_requests++;
            end
            if (p == 4) begin
                run_random_events(PHASE_EVENTS / 2);
                // pause the source until every reading is back
                wait_drained();
            end
            run_random_events(PHASE_EVENTS);
        end
        steady = 1'b0;

        // Let the last readings out, then allow for stray beats
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tacho.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
